>>> hw/rtl/rtc_pkg.sv
// Shared types, constants and the multiply-accumulate program of the
// ray/triangle closest-hit unit. No dependencies.
package rtc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DIST_W          = 31;
  localparam int CFG_IDX_W       = 3;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd6;

  // operand sources
  localparam logic [4:0] SRC_DIR0 = 5'd0;
  localparam logic [4:0] SRC_DIR1 = 5'd1;
  localparam logic [4:0] SRC_DIR2 = 5'd2;
  localparam logic [4:0] SRC_E10  = 5'd3;
  localparam logic [4:0] SRC_E11  = 5'd4;
  localparam logic [4:0] SRC_E12  = 5'd5;
  localparam logic [4:0] SRC_E20  = 5'd6;
  localparam logic [4:0] SRC_E21  = 5'd7;
  localparam logic [4:0] SRC_E22  = 5'd8;
  localparam logic [4:0] SRC_S0   = 5'd9;
  localparam logic [4:0] SRC_S1   = 5'd10;
  localparam logic [4:0] SRC_S2   = 5'd11;
  localparam logic [4:0] SRC_H0   = 5'd12;
  localparam logic [4:0] SRC_H1   = 5'd13;
  localparam logic [4:0] SRC_H2   = 5'd14;
  localparam logic [4:0] SRC_Q0   = 5'd15;
  localparam logic [4:0] SRC_Q1   = 5'd16;
  localparam logic [4:0] SRC_Q2   = 5'd17;

  // result destinations
  localparam logic [3:0] DST_H0  = 4'd0;
  localparam logic [3:0] DST_H1  = 4'd1;
  localparam logic [3:0] DST_H2  = 4'd2;
  localparam logic [3:0] DST_Q0  = 4'd3;
  localparam logic [3:0] DST_Q1  = 4'd4;
  localparam logic [3:0] DST_Q2  = 4'd5;
  localparam logic [3:0] DST_DET = 4'd6;
  localparam logic [3:0] DST_UN  = 4'd7;
  localparam logic [3:0] DST_VN  = 4'd8;
  localparam logic [3:0] DST_TN  = 4'd9;

  localparam int NUM_STEPS = 24;
  localparam logic [4:0] LAST_STEP = 5'd23;

  typedef struct packed {
    logic [4:0] a_src;
    logic [4:0] b_src;
    logic       neg;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } step_t;

  function automatic step_t mk(input logic [4:0] a, input logic [4:0] b, input logic n,
                               input logic f, input logic l, input logic [3:0] d);
    step_t s;
    s.a_src = a;
    s.b_src = b;
    s.neg   = n;
    s.first = f;
    s.last  = l;
    s.dest  = d;
    return s;
  endfunction

  function automatic step_t get_step(input logic [4:0] i);
    step_t s;
    case (i)
      5'd0:  s = mk(SRC_DIR1, SRC_E22, 1'b0, 1'b1, 1'b0, DST_H0);
      5'd1:  s = mk(SRC_DIR2, SRC_E21, 1'b1, 1'b0, 1'b1, DST_H0);
      5'd2:  s = mk(SRC_DIR2, SRC_E20, 1'b0, 1'b1, 1'b0, DST_H1);
      5'd3:  s = mk(SRC_DIR0, SRC_E22, 1'b1, 1'b0, 1'b1, DST_H1);
      5'd4:  s = mk(SRC_DIR0, SRC_E21, 1'b0, 1'b1, 1'b0, DST_H2);
      5'd5:  s = mk(SRC_DIR1, SRC_E20, 1'b1, 1'b0, 1'b1, DST_H2);
      5'd6:  s = mk(SRC_S1,   SRC_E12, 1'b0, 1'b1, 1'b0, DST_Q0);
      5'd7:  s = mk(SRC_S2,   SRC_E11, 1'b1, 1'b0, 1'b1, DST_Q0);
      5'd8:  s = mk(SRC_S2,   SRC_E10, 1'b0, 1'b1, 1'b0, DST_Q1);
      5'd9:  s = mk(SRC_S0,   SRC_E12, 1'b1, 1'b0, 1'b1, DST_Q1);
      5'd10: s = mk(SRC_S0,   SRC_E11, 1'b0, 1'b1, 1'b0, DST_Q2);
      5'd11: s = mk(SRC_S1,   SRC_E10, 1'b1, 1'b0, 1'b1, DST_Q2);
      5'd12: s = mk(SRC_H0,   SRC_E10, 1'b0, 1'b1, 1'b0, DST_DET);
      5'd13: s = mk(SRC_H1,   SRC_E11, 1'b0, 1'b0, 1'b0, DST_DET);
      5'd14: s = mk(SRC_H2,   SRC_E12, 1'b0, 1'b0, 1'b1, DST_DET);
      5'd15: s = mk(SRC_H0,   SRC_S0,  1'b0, 1'b1, 1'b0, DST_UN);
      5'd16: s = mk(SRC_H1,   SRC_S1,  1'b0, 1'b0, 1'b0, DST_UN);
      5'd17: s = mk(SRC_H2,   SRC_S2,  1'b0, 1'b0, 1'b1, DST_UN);
      5'd18: s = mk(SRC_Q0,   SRC_DIR0, 1'b0, 1'b1, 1'b0, DST_VN);
      5'd19: s = mk(SRC_Q1,   SRC_DIR1, 1'b0, 1'b0, 1'b0, DST_VN);
      5'd20: s = mk(SRC_Q2,   SRC_DIR2, 1'b0, 1'b0, 1'b1, DST_VN);
      5'd21: s = mk(SRC_Q0,   SRC_E20, 1'b0, 1'b1, 1'b0, DST_TN);
      5'd22: s = mk(SRC_Q1,   SRC_E21, 1'b0, 1'b0, 1'b0, DST_TN);
      5'd23: s = mk(SRC_Q2,   SRC_E22, 1'b0, 1'b0, 1'b1, DST_TN);
      default: s = mk(SRC_DIR0, SRC_DIR0, 1'b0, 1'b1, 1'b1, DST_H0);
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/rtc_front.sv
// Front end: accepts triangle transactions and forms edge and origin offset
// vectors for the back end. Depends on rtc_pkg.
module rtc_front import rtc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] vertex0_x,
  input  logic [COORD_WIDTH-1:0] vertex0_y,
  input  logic [COORD_WIDTH-1:0] vertex0_z,
  input  logic [COORD_WIDTH-1:0] vertex1_x,
  input  logic [COORD_WIDTH-1:0] vertex1_y,
  input  logic [COORD_WIDTH-1:0] vertex1_z,
  input  logic [COORD_WIDTH-1:0] vertex2_x,
  input  logic [COORD_WIDTH-1:0] vertex2_y,
  input  logic [COORD_WIDTH-1:0] vertex2_z,
  input  logic                   last_triangle,
  input  logic [COORD_WIDTH-1:0] origin_x,
  input  logic [COORD_WIDTH-1:0] origin_y,
  input  logic [COORD_WIDTH-1:0] origin_z,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [9*(COORD_WIDTH+1):0] push_data
);

  localparam int EW = COORD_WIDTH + 1;

  logic          hold_valid;
  logic [9*EW:0] hold_data;

  function automatic logic [EW-1:0] dif(input logic [COORD_WIDTH-1:0] a,
                                        input logic [COORD_WIDTH-1:0] b);
    return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_data  = hold_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_data <= {last_triangle,
                    dif(origin_z, vertex0_z), dif(origin_y, vertex0_y),
                    dif(origin_x, vertex0_x),
                    dif(vertex2_z, vertex0_z), dif(vertex2_y, vertex0_y),
                    dif(vertex2_x, vertex0_x),
                    dif(vertex1_z, vertex0_z), dif(vertex1_y, vertex0_y),
                    dif(vertex1_x, vertex0_x)};
    end
  end

endmodule

>>> hw/rtl/rtc_fifo.sv
// Two-entry queue between front and back end. Depends on rtc_pkg.
module rtc_fifo import rtc_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) mem[wr_ptr] <= push_data;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !do_pop) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/rtc_back.sv
// Back end: bit-serial multiply-accumulate over the intersection products,
// the inside tests, restoring division for t and the closest-hit state.
// Depends on rtc_pkg.
module rtc_back import rtc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  logic [9*(COORD_WIDTH+1):0] head_data,
  output logic                       head_pop,
  input  logic [COORD_WIDTH-1:0]     dir_x,
  input  logic [COORD_WIDTH-1:0]     dir_y,
  input  logic [COORD_WIDTH-1:0]     dir_z,
  input  logic [DIST_W-1:0]          eps,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       triangle_hit,
  output logic [DIST_W-1:0]          triangle_distance,
  output logic                       any_hit,
  output logic [DIST_W-1:0]          closest_distance,
  output logic                       mesh_done
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int HW = 2 * EW + 1;
  localparam int DW = 3 * EW + 3;
  localparam int QW = DW + 32;
  localparam int BW = $clog2(EW);
  localparam logic [BW-1:0] BIT_LAST = BW'(EW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MLD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state;
  logic [4:0]        step_idx;
  logic [BW-1:0]     bitc;
  logic [DW-1:0]     acc;
  logic [DW-1:0]     pp;
  logic [EW-1:0]     mb;
  logic [HW-1:0]     h0, h1, h2, q0, q1, q2;
  logic [DW-1:0]     det, un, vn, tn;
  logic              ok;
  logic [QW-1:0]     rem;
  logic [QW-1:0]     dvs;
  logic [4:0]        qcnt;
  logic [DIST_W-1:0] tq;
  logic [DIST_W-1:0] best;
  logic              found;

  step_t         st;
  logic [HW-1:0] a_val;
  logic [EW-1:0] b_val;
  logic [DW-1:0] addend;
  logic          sub;
  logic [DW-1:0] acc_next;
  logic [EW-1:0] e1_0, e1_1, e1_2, e2_0, e2_1, e2_2, s_0, s_1, s_2;
  logic [EW-1:0] d_0, d_1, d_2;
  logic          last_in;
  logic          neg;
  logic [DW:0]   uv_sum;
  logic          pass;
  logic [QW-1:0] eps_sh;
  logic [QW-1:0] num;
  logic [QW-1:0] sat_lim;
  logic          hit;
  logic          out_free;

  assign e1_0    = head_data[0*EW +: EW];
  assign e1_1    = head_data[1*EW +: EW];
  assign e1_2    = head_data[2*EW +: EW];
  assign e2_0    = head_data[3*EW +: EW];
  assign e2_1    = head_data[4*EW +: EW];
  assign e2_2    = head_data[5*EW +: EW];
  assign s_0     = head_data[6*EW +: EW];
  assign s_1     = head_data[7*EW +: EW];
  assign s_2     = head_data[8*EW +: EW];
  assign last_in = head_data[9*EW];
  assign d_0     = {dir_x[COORD_WIDTH-1], dir_x};
  assign d_1     = {dir_y[COORD_WIDTH-1], dir_y};
  assign d_2     = {dir_z[COORD_WIDTH-1], dir_z};

  function automatic logic [HW-1:0] sx(input logic [EW-1:0] v);
    return {{(HW-EW){v[EW-1]}}, v};
  endfunction

  always_comb begin
    st = get_step(step_idx);
    case (st.a_src)
      SRC_DIR0: a_val = sx(d_0);
      SRC_DIR1: a_val = sx(d_1);
      SRC_DIR2: a_val = sx(d_2);
      SRC_S0:   a_val = sx(s_0);
      SRC_S1:   a_val = sx(s_1);
      SRC_S2:   a_val = sx(s_2);
      SRC_H0:   a_val = h0;
      SRC_H1:   a_val = h1;
      SRC_H2:   a_val = h2;
      SRC_Q0:   a_val = q0;
      SRC_Q1:   a_val = q1;
      SRC_Q2:   a_val = q2;
      default:  a_val = '0;
    endcase
    case (st.b_src)
      SRC_DIR0: b_val = d_0;
      SRC_DIR1: b_val = d_1;
      SRC_DIR2: b_val = d_2;
      SRC_E10:  b_val = e1_0;
      SRC_E11:  b_val = e1_1;
      SRC_E12:  b_val = e1_2;
      SRC_E20:  b_val = e2_0;
      SRC_E21:  b_val = e2_1;
      SRC_E22:  b_val = e2_2;
      SRC_S0:   b_val = s_0;
      SRC_S1:   b_val = s_1;
      SRC_S2:   b_val = s_2;
      default:  b_val = '0;
    endcase
  end

  // signed multiplier bit: the top bit of b carries negative weight
  assign sub      = (bitc == BIT_LAST) ^ st.neg;
  assign addend   = mb[0] ? pp : '0;
  assign acc_next = sub ? (acc - addend) : (acc + addend);

  assign neg     = det[DW-1];
  assign uv_sum  = {1'b0, un} + {1'b0, vn};
  assign eps_sh  = QW'(eps) << (2 * FRAC_BITS);
  assign num     = QW'(tn) << FRAC_BITS;
  assign sat_lim = QW'(det) << DIST_W;
  assign pass    = (det != '0) && (QW'(det) >= eps_sh) && !un[DW-1] && (un <= det)
                   && !vn[DW-1] && (uv_sum <= {1'b0, det}) && !tn[DW-1];
  assign hit      = ok && (tq > eps);
  assign out_free = !out_valid || out_ready;
  assign head_pop = (state == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_idx  <= '0;
      bitc      <= '0;
      out_valid <= 1'b0;
      best      <= DIST_MAX;
      found     <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            step_idx <= '0;
            state    <= S_MLD;
          end
        end
        S_MLD: begin
          pp    <= {{(DW-HW){a_val[HW-1]}}, a_val};
          mb    <= b_val;
          bitc  <= '0;
          if (st.first) acc <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc  <= acc_next;
          pp   <= pp << 1;
          mb   <= mb >> 1;
          bitc <= bitc + 1'b1;
          if (bitc == BIT_LAST) begin
            if (st.last) begin
              case (st.dest)
                DST_H0:  h0  <= acc_next[HW-1:0];
                DST_H1:  h1  <= acc_next[HW-1:0];
                DST_H2:  h2  <= acc_next[HW-1:0];
                DST_Q0:  q0  <= acc_next[HW-1:0];
                DST_Q1:  q1  <= acc_next[HW-1:0];
                DST_Q2:  q2  <= acc_next[HW-1:0];
                DST_DET: det <= acc_next;
                DST_UN:  un  <= acc_next;
                DST_VN:  vn  <= acc_next;
                DST_TN:  tn  <= acc_next;
                default: ;
              endcase
            end
            if (step_idx == LAST_STEP) begin
              state <= S_FIX;
            end else begin
              step_idx <= step_idx + 1'b1;
              state    <= S_MLD;
            end
          end
        end
        S_FIX: begin
          if (neg) begin
            det <= -det;
            un  <= -un;
            vn  <= -vn;
            tn  <= -tn;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          ok <= pass;
          if (!pass) begin
            tq    <= '0;
            state <= S_FIN;
          end else if (num >= sat_lim) begin
            tq    <= DIST_MAX;
            state <= S_FIN;
          end else begin
            tq    <= '0;
            rem   <= num;
            dvs   <= QW'(det) << (DIST_W - 1);
            qcnt  <= 5'(DIST_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= dvs) begin
            rem <= rem - dvs;
            tq  <= {tq[DIST_W-2:0], 1'b1};
          end else begin
            tq  <= {tq[DIST_W-2:0], 1'b0};
          end
          dvs  <= dvs >> 1;
          qcnt <= qcnt - 1'b1;
          if (qcnt == '0) state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            triangle_hit      <= hit;
            triangle_distance <= hit ? tq : '0;
            any_hit           <= found || hit;
            closest_distance  <= (hit && (tq < best)) ? tq : best;
            mesh_done         <= last_in;
            if (last_in) begin
              found <= 1'b0;
              best  <= DIST_MAX;
            end else if (hit) begin
              found <= 1'b1;
              if (tq < best) best <= tq;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_only_on_pass: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ok) else $error("division on rejected triangle");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !triangle_hit) |-> (triangle_distance == '0))
    else $error("distance on a miss");
  a_closest_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && triangle_hit) |-> (any_hit && closest_distance <= triangle_distance))
    else $error("closest distance above this hit");
  a_pop_only_fin: assert property (@(posedge clk) disable iff (rst)
    head_pop |=> (state == S_IDLE && out_valid)) else $error("pop without result");
`endif

endmodule

>>> hw/rtl/ray_triangle_closest_hit_unit.sv
// Ray/triangle closest-hit unit: top level with configuration registers.
// Instantiates rtc_front, rtc_fifo and rtc_back; depends on rtc_pkg.
//
// Streams the triangles of one mesh against a ray held in registers and
// applies the Moller-Trumbore test in exact integer arithmetic. Each triangle
// transaction yields one result with its own hit and t, the running closest t
// and any-hit flag; the running state clears after the transaction flagged
// last_triangle. All products go through one shared bit-serial
// multiply-accumulate unit (24 products), then a restoring divider forms t.
// A two-entry queue, which also holds the triangle in work, and the front-end
// register let two more triangles be accepted while one is in work, and a
// finished result waits in an output register. Write configuration only
// while the unit is idle.
module ray_triangle_closest_hit_unit import rtc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int DATA_W     = (COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] vertex0_x,
  input  logic [COORD_WIDTH-1:0] vertex0_y,
  input  logic [COORD_WIDTH-1:0] vertex0_z,
  input  logic [COORD_WIDTH-1:0] vertex1_x,
  input  logic [COORD_WIDTH-1:0] vertex1_y,
  input  logic [COORD_WIDTH-1:0] vertex1_z,
  input  logic [COORD_WIDTH-1:0] vertex2_x,
  input  logic [COORD_WIDTH-1:0] vertex2_y,
  input  logic [COORD_WIDTH-1:0] vertex2_z,
  input  logic                   last_triangle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   triangle_hit,
  output logic [DIST_W-1:0]      triangle_distance,
  output logic                   any_hit,
  output logic [DIST_W-1:0]      closest_distance,
  output logic                   mesh_done
);

  localparam int QDW = 9 * (COORD_WIDTH + 1) + 1;

  logic [COORD_WIDTH-1:0] origin_x, origin_y, origin_z;
  logic [COORD_WIDTH-1:0] direction_x, direction_y, direction_z;
  logic [DIST_W-1:0]      parallel_epsilon;
  logic                   push_valid, push_ready;
  logic [QDW-1:0]         push_data;
  logic                   head_valid, head_pop;
  logic [QDW-1:0]         head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x         <= '0;
      origin_y         <= '0;
      origin_z         <= '0;
      direction_x      <= '0;
      direction_y      <= '0;
      direction_z      <= COORD_WIDTH'(1) << FRAC_BITS;
      parallel_epsilon <= DIST_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x         <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: origin_y         <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: origin_z         <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_X:    direction_x      <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_Y:    direction_y      <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_Z:    direction_z      <= cfg_data[COORD_WIDTH-1:0];
        REG_EPSILON:  parallel_epsilon <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  rtc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .vertex0_x, .vertex0_y, .vertex0_z,
    .vertex1_x, .vertex1_y, .vertex1_z,
    .vertex2_x, .vertex2_y, .vertex2_z,
    .last_triangle, .origin_x, .origin_y, .origin_z,
    .push_valid, .push_ready, .push_data
  );

  rtc_fifo #(.WIDTH(QDW)) u_fifo (
    .clk, .rst, .push_valid, .push_ready, .push_data,
    .pop_valid(head_valid), .pop(head_pop), .pop_data(head_data)
  );

  rtc_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .head_valid, .head_data, .head_pop,
    .dir_x(direction_x), .dir_y(direction_y), .dir_z(direction_z),
    .eps(parallel_epsilon), .out_valid, .out_ready,
    .triangle_hit, .triangle_distance, .any_hit, .closest_distance, .mesh_done
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for ray_triangle_closest_hit_unit: streams triangles against several ray settings
// and checks every result against an exact wide-integer closest-hit predictor. Needs rtc_pkg.
module tb;
  import rtc_pkg::*;

  localparam int LIMIT = 4000000;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [8:0][31:0] v;
    logic             last;
  } triangle_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] tdist;
    logic        any;
    logic [30:0] closest;
    logic        done;
  } hit_result_t;

  class hit_scoreboard;
    logic [31:0]   ray_reg[7];
    logic [30:0]   best;
    logic          found;
    hit_result_t   expected_q[$];
    int            errors;

    function new();
      foreach (ray_reg[i]) ray_reg[i] = '0;
      ray_reg[REG_DIR_Z]   = 32'd65536;
      ray_reg[REG_EPSILON] = 32'd1;
      best   = DIST_MAX;
      found  = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      ray_reg[idx] = (idx == REG_EPSILON) ? {1'b0, data[30:0]} : data;
    endfunction

    function wide_t dot3(wide_t a0, wide_t a1, wide_t a2, wide_t b0, wide_t b1, wide_t b2);
      return a0 * b0 + a1 * b1 + a2 * b2;
    endfunction

    function void note_triangle(triangle_t t);
      wide_t org[3], dir[3], v0[3], e1[3], e2[3], s[3], h[3], q[3];
      wide_t det, un, vn, tn, num, quo, eps;
      logic [30:0] tq;
      logic hit;
      hit_result_t r;
      for (int i = 0; i < 3; i++) begin
        org[i] = wide_t'($signed(ray_reg[i]));
        dir[i] = wide_t'($signed(ray_reg[3 + i]));
        v0[i]  = wide_t'($signed(t.v[i]));
        e1[i]  = wide_t'($signed(t.v[3 + i])) - v0[i];
        e2[i]  = wide_t'($signed(t.v[6 + i])) - v0[i];
        s[i]   = org[i] - v0[i];
      end
      h[0] = dir[1] * e2[2] - dir[2] * e2[1];
      h[1] = dir[2] * e2[0] - dir[0] * e2[2];
      h[2] = dir[0] * e2[1] - dir[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      det = dot3(e1[0], e1[1], e1[2], h[0], h[1], h[2]);
      un  = dot3(s[0], s[1], s[2], h[0], h[1], h[2]);
      vn  = dot3(dir[0], dir[1], dir[2], q[0], q[1], q[2]);
      tn  = dot3(e2[0], e2[1], e2[2], q[0], q[1], q[2]);
      if (det < 0) begin
        det = -det;
        un  = -un;
        vn  = -vn;
        tn  = -tn;
      end
      eps = wide_t'(ray_reg[REG_EPSILON]);
      tq  = '0;
      hit = 1'b0;
      if (det != 0 && det >= (eps <<< 32) && un >= 0 && un <= det && vn >= 0 &&
          un + vn <= det && tn >= 0) begin
        num = tn <<< FRAC_BITS_DEF;
        quo = num / det;
        tq  = (quo >= wide_t'(DIST_MAX)) ? DIST_MAX : quo[30:0];
        hit = ({1'b0, tq} > ray_reg[REG_EPSILON]);
      end
      if (hit) begin
        found = 1'b1;
        if (tq < best) best = tq;
      end else begin
        tq = '0;
      end
      r.hit     = hit;
      r.tdist   = tq;
      r.any     = found;
      r.closest = best;
      r.done    = t.last;
      expected_q.insert(expected_q.size(), r);
      if (t.last) begin
        best  = DIST_MAX;
        found = 1'b0;
      end
    endfunction

    function void check_result(hit_result_t got);
      hit_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.hit != e.hit || got.tdist != e.tdist || got.any != e.any ||
          got.closest != e.closest || got.done != e.done) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp hit=%0d t=%0d any=%0d closest=%0d done=%0d",
                    " / got hit=%0d t=%0d any=%0d closest=%0d done=%0d"},
                   e.hit, e.tdist, e.any, e.closest, e.done,
                   got.hit, got.tdist, got.any, got.closest, got.done);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [8:0][31:0] vtx = '0;
  logic        last_triangle = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        triangle_hit, any_hit, mesh_done;
  logic [30:0] triangle_distance, closest_distance;

  hit_scoreboard sb = new();
  int cycles = 0;
  int mesh_left = 0;

  ray_triangle_closest_hit_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex0_x(vtx[0]), .vertex0_y(vtx[1]), .vertex0_z(vtx[2]),
    .vertex1_x(vtx[3]), .vertex1_y(vtx[4]), .vertex1_z(vtx[5]),
    .vertex2_x(vtx[6]), .vertex2_y(vtx[7]), .vertex2_z(vtx[8]),
    .last_triangle(last_triangle),
    .out_valid(out_valid), .out_ready(out_ready),
    .triangle_hit(triangle_hit), .triangle_distance(triangle_distance),
    .any_hit(any_hit), .closest_distance(closest_distance), .mesh_done(mesh_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_triangle({vtx, last_triangle});
    if (!rst && out_valid && out_ready)
      sb.check_result({triangle_hit, triangle_distance, any_hit, closest_distance, mesh_done});
  end

  // receiver: alternating ready/stall windows, with long quiet stretches of no stalls
  int rdy_left = 0;
  always @(posedge clk) begin
    if ((cycles / 20000) % 3 == 2) begin
      out_ready <= 1'b1;
    end else if (rdy_left == 0) begin
      out_ready <= ~out_ready;
      rdy_left  <= $urandom_range(1, 60);
    end else begin
      rdy_left <= rdy_left - 1;
    end
  end

  task automatic write_ray(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, logic [31:0] eps);
    drain();
    write_ray(REG_ORIGIN_X, ox);
    write_ray(REG_ORIGIN_Y, oy);
    write_ray(REG_ORIGIN_Z, oz);
    write_ray(REG_DIR_X, dx);
    write_ray(REG_DIR_Y, dy);
    write_ray(REG_DIR_Z, dz);
    write_ray(REG_EPSILON, eps);
    cfg_we <= 1'b0;
  endtask

  task automatic send_triangle(triangle_t t);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 25);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    vtx           <= t.v;
    last_triangle <= t.last;
    do @(posedge clk); while (!in_ready);
  endtask

  // directed triangle in whole units
  task automatic send_units(int a0, int a1, int a2, int b0, int b1, int b2,
                            int c0, int c1, int c2, logic last);
    triangle_t t;
    t.v[0] = a0 <<< 16; t.v[1] = a1 <<< 16; t.v[2] = a2 <<< 16;
    t.v[3] = b0 <<< 16; t.v[4] = b1 <<< 16; t.v[5] = b2 <<< 16;
    t.v[6] = c0 <<< 16; t.v[7] = c1 <<< 16; t.v[8] = c2 <<< 16;
    t.last = last;
    send_triangle(t);
  endtask

  task automatic send_random(int n);
    triangle_t t;
    int k, kind, c[3];
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      k = (kind < 85) ? $urandom_range(1, 40) : -$urandom_range(1, 40);
      for (int j = 0; j < 3; j++)
        c[j] = sb.ray_reg[j] + $signed(sb.ray_reg[3 + j]) * k;
      for (int j = 0; j < 9; j++) begin
        if (kind < 70 || kind >= 85)
          t.v[j] = c[j % 3] + $urandom_range(0, 16 << 16) - (8 << 16);
        else
          t.v[j] = $urandom();
      end
      if (mesh_left == 0) mesh_left = $urandom_range(1, 8);
      mesh_left--;
      t.last = (mesh_left == 0);
      send_triangle(t);
    end
  endtask

  initial begin
    triangle_t t;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset ray: origin 0, direction +z, epsilon 1 LSB
    send_units(-1, -1, 5, 3, -1, 5, -1, 3, 5, 1'b0);
    send_units(-1, -1, 9, 3, -1, 9, -1, 3, 9, 1'b0);
    send_units(-1, -1, 5, 3, -1, 5, -1, 3, 5, 1'b0);
    send_units(-1, -1, 2, 3, -1, 2, -1, 3, 2, 1'b1);
    send_units(-1, -1, -5, 3, -1, -5, -1, 3, -5, 1'b0);
    send_units(2, 0, 0, 2, 1, 0, 2, 0, 1, 1'b0);
    send_units(10, 10, 5, 12, 10, 5, 10, 12, 5, 1'b0);
    send_units(0, 0, 3, 1, 0, 3, 0, 1, 3, 1'b0);
    send_units(-1, 0, 4, 1, 0, 4, 0, 2, 4, 1'b0);
    send_units(1, -1, 4, 1, 1, 4, -1, 1, 4, 1'b0);
    send_units(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    t.v = {9{32'h7FFFFFFF}}; t.last = 1'b0; send_triangle(t);
    t.v = {9{32'h80000000}}; t.last = 1'b1; send_triangle(t);
    t.v = {32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
           32'h1, 32'h80000000, 32'h7FFFFFFF};
    t.last = 1'b1; send_triangle(t);

    // tiny direction drives t into saturation; epsilon 0 still rejects zero determinant
    set_ray(0, 0, 0, 0, 0, 1, 0);
    send_units(-1, -1, 100, 3, -1, 100, -1, 3, 100, 1'b0);
    send_units(2, 0, 0, 2, 1, 0, 2, 0, 1, 1'b1);

    // largest epsilon rejects everything ordinary
    set_ray(0, 0, 0, 0, 0, 65536, 32'h7FFFFFFF);
    send_units(-1, -1, 5, 3, -1, 5, -1, 3, 5, 1'b1);
    send_random(20);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_ray(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 1, 0);
        1: set_ray(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF, 5);
        default:
          set_ray($urandom_range(0, 200 << 16) - (100 << 16),
                  $urandom_range(0, 200 << 16) - (100 << 16),
                  $urandom_range(0, 200 << 16) - (100 << 16),
                  $urandom_range(0, 8 << 16) - (4 << 16),
                  $urandom_range(0, 8 << 16) - (4 << 16),
                  $urandom_range(0, 8 << 16) - (4 << 16),
                  (ph == 6) ? $urandom() & 32'h7FFFFFFF : $urandom_range(0, 256));
      endcase
      send_random(ph < 2 ? 40 : 110);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
